// ===== design/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the mirror
// sector CRC checker.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int unsigned CRC_W          = 32;
   localparam int unsigned SECTOR_W       = 32;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned TABLE_SECTOR_W = 33;
   localparam int unsigned SLOT_W         = 7;
   localparam int unsigned REQ_USER_W     = 2;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   // CRC entries held in one table sector
   localparam int unsigned SLOTS_PER_TABLE_SECTOR = 128;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   // tdata layouts, last declared field in the lowest bits
   typedef struct packed {
      logic [CRC_W-1:0]    stored_crc_b;
      logic [CRC_W-1:0]    stored_crc_a;
      logic [BYTE_W-1:0]   byte_b;
      logic [BYTE_W-1:0]   byte_a;
      logic [SECTOR_W-1:0] sector_number;
   } req_data_type;

   typedef struct packed {
      logic [1:0]                pad;
      logic                      write_back_b;
      logic                      write_back_a;
      logic                      request_error;
      logic [CRC_W-1:0]          new_crc_b;
      logic [CRC_W-1:0]          new_crc_a;
      logic                      unrecoverable;
      logic                      copy_b_bad;
      logic                      copy_a_bad;
      logic [SLOT_W-1:0]         crc_slot;
      logic [TABLE_SECTOR_W-1:0] crc_table_sector;
      logic [SECTOR_W-1:0]       done_sector;
   } rsp_data_type;

   localparam int unsigned REQ_DATA_W = $bits(req_data_type);
   localparam int unsigned RSP_DATA_W = $bits(rsp_data_type);

   // bit positions in rsp tdata, used by the port checker
   localparam int unsigned RSP_A_BAD_BIT   = 72;
   localparam int unsigned RSP_B_BAD_BIT   = 73;
   localparam int unsigned RSP_UNREC_BIT   = 74;
   localparam int unsigned RSP_REQ_ERR_BIT = 139;
   localparam int unsigned RSP_WB_A_BIT    = 140;
   localparam int unsigned RSP_WB_B_BIT    = 141;

   // registered input item handed from the input stage to the check core
   typedef struct packed {
      cmd_type      command;
      logic         last_in_request;
      logic         last_in_sector;
      req_data_type data;
   } req_item_type;

   // reflected CRC-32, one byte, seed and inversion handled by caller
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

// ===== design/msc_in_stage.sv =====
// ----------------------------------------------------------------------------
// msc_in_stage
// Input register: captures one byte-pair transfer and holds it until the
// check core takes it.
// ----------------------------------------------------------------------------
module msc_in_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [msc_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic                                   req_tlast,
   input  logic [msc_pkg::REQ_USER_W-1:0]         req_tuser,
   output logic                                   item_valid,
   input  logic                                   item_ready,
   output msc_pkg::req_item_type                  item
);
   import msc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in                = 1'b1;
         item_in.command         = cmd_type'(req_tuser[0]);
         item_in.last_in_request = req_tuser[1];
         item_in.last_in_sector  = req_tlast;
         item_in.data            = req_tdata;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/msc_check_core.sv =====
// ----------------------------------------------------------------------------
// msc_check_core
// Running CRCs of both copies, sector verdict, request flags and the
// result register.
// ----------------------------------------------------------------------------
module msc_check_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [msc_pkg::SECTOR_W-1:0]           region_start,
   input  logic                                   item_valid,
   output logic                                   item_ready,
   input  msc_pkg::req_item_type                  item,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [msc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast
);
   import msc_pkg::*;

   logic [CRC_W-1:0] crc_a_ff, crc_a_in;
   logic [CRC_W-1:0] crc_b_ff, crc_b_in;
   logic             err_ff, err_in;
   logic             chg_a_ff, chg_a_in;
   logic             chg_b_ff, chg_b_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             fire, sector_end, is_write;
   logic [CRC_W-1:0] ca, cb;
   logic             a_bad, b_bad, unrec, err_now, chg_a_now, chg_b_now;
   logic [SECTOR_W-1:0] quot, rem;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid && item_ready;
   assign is_write   = (item.command == CMD_WRITE);
   assign sector_end = item.last_in_sector || item.last_in_request;

   assign quot = item.data.sector_number / SLOTS_PER_TABLE_SECTOR;
   assign rem  = item.data.sector_number % SLOTS_PER_TABLE_SECTOR;

   always_comb begin
      ca = crc_byte(crc_a_ff, item.data.byte_a);
      cb = is_write ? crc_b_ff : crc_byte(crc_b_ff, item.data.byte_b);

      a_bad = !is_write && (ca != item.data.stored_crc_a);
      b_bad = !is_write && (cb != item.data.stored_crc_b);
      unrec = a_bad && b_bad;

      err_now   = err_ff || unrec;
      chg_a_now = chg_a_ff || is_write || a_bad;
      chg_b_now = chg_b_ff || is_write || b_bad;

      crc_a_in     = crc_a_ff;
      crc_b_in     = crc_b_ff;
      err_in       = err_ff;
      chg_a_in     = chg_a_ff;
      chg_b_in     = chg_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (fire) begin
         crc_a_in = ca;
         crc_b_in = cb;
         if (sector_end) begin
            crc_a_in = '0;
            crc_b_in = '0;
            err_in   = err_now;
            chg_a_in = chg_a_now;
            chg_b_in = chg_b_now;
            if (item.last_in_request) begin
               err_in   = 1'b0;
               chg_a_in = 1'b0;
               chg_b_in = 1'b0;
            end

            rsp_valid_in                 = 1'b1;
            rsp_last_in                  = item.last_in_request;
            rsp_data_in.pad              = '0;
            rsp_data_in.done_sector      = item.data.sector_number;
            rsp_data_in.crc_table_sector = TABLE_SECTOR_W'(region_start)
                                           + TABLE_SECTOR_W'(quot);
            rsp_data_in.crc_slot         = rem[SLOT_W-1:0];
            rsp_data_in.copy_a_bad       = a_bad;
            rsp_data_in.copy_b_bad       = b_bad;
            rsp_data_in.unrecoverable    = unrec;
            if (is_write) begin
               rsp_data_in.new_crc_a = ca;
               rsp_data_in.new_crc_b = ca;
            end else begin
               rsp_data_in.new_crc_a = a_bad ? cb : item.data.stored_crc_a;
               rsp_data_in.new_crc_b = b_bad ? ca : item.data.stored_crc_b;
            end
            rsp_data_in.request_error = item.last_in_request && err_now;
            rsp_data_in.write_back_a  = item.last_in_request && !err_now && chg_a_now;
            rsp_data_in.write_back_b  = item.last_in_request && !err_now && chg_b_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_a_ff     <= '0;
         crc_b_ff     <= '0;
         err_ff       <= 1'b0;
         chg_a_ff     <= 1'b0;
         chg_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_a_ff     <= crc_a_in;
         crc_b_ff     <= crc_b_in;
         err_ff       <= err_in;
         chg_a_ff     <= chg_a_in;
         chg_b_ff     <= chg_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/mirror_sector_crc_checker_unit.sv =====
// ----------------------------------------------------------------------------
// mirror_sector_crc_checker_unit
// CRC-32 check of two mirrored sector copies, with per-sector verdict and
// per-request error and table write-back flags.
// ----------------------------------------------------------------------------
//  channel  dir  moves                               completes on
//  req      in   one byte pair of both copies        req_tvalid & req_tready
//  rsp      out  one verdict per sector end          rsp_tvalid & rsp_tready
//  csr      in   crc_region_start                    csr_wr_en
//
//  One byte pair per cycle sustained unless a stalled rsp holds the pipe; a
//  verdict passes the input register, then CRC/verdict into the result reg.
//  The byte-wide CRC update plus compare sits between the two registers.
//  reset clears running CRCs, request flags, region start and both valids.
//  A stalled rsp holds its result; the byte pipe keeps moving while the
//  result register is free or is being drained in the same cycle.
// ----------------------------------------------------------------------------
module mirror_sector_crc_checker_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sector_number, byte_a, byte_b, stored_crc_a, stored_crc_b
   input  logic [msc_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  logic                                   req_tlast,
   // command, last_in_request
   input  logic [msc_pkg::REQ_USER_W-1:0]         req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // done_sector, crc_table_sector, crc_slot, copy_a_bad, copy_b_bad,
   // unrecoverable, new_crc_a, new_crc_b, request_error, write_back_a,
   // write_back_b, 2 zero bits
   output logic [msc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_wr_en,
   input  logic [msc_pkg::SECTOR_W-1:0]           csr_wr_data
);
   import msc_pkg::*;

   logic [SECTOR_W-1:0] region_ff;
   logic                item_valid, item_ready;
   req_item_type        item;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= '0;
      end else if (csr_wr_en) begin
         region_ff <= csr_wr_data;
      end
   end

   msc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   msc_check_core u_check_core (
      .clock        (clock),
      .reset        (reset),
      .region_start (region_ff),
      .item_valid   (item_valid),
      .item_ready   (item_ready),
      .item         (item),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== design/msc_port_checker.sv =====
// ----------------------------------------------------------------------------
// msc_port_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module msc_port_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [msc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  logic                                   rsp_tlast
);
   import msc_pkg::*;

   // stalled result stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   // unrecoverable only when both copies are bad
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_UNREC_BIT] |->
         rsp_tdata[RSP_A_BAD_BIT] && rsp_tdata[RSP_B_BAD_BIT])
      else $error("unrecoverable without both copies bad");

   // request flags only on the closing result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         !rsp_tdata[RSP_REQ_ERR_BIT] && !rsp_tdata[RSP_WB_A_BIT]
         && !rsp_tdata[RSP_WB_B_BIT])
      else $error("request flags set before request end");

   // write-back suppressed on request error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_REQ_ERR_BIT] |->
         !rsp_tdata[RSP_WB_A_BIT] && !rsp_tdata[RSP_WB_B_BIT])
      else $error("table write-back flagged on failed request");

endmodule

bind mirror_sector_crc_checker_unit msc_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
